// ----- hw/rtl/dlc_pkg.sv -----
// Shared types, codes and the CRC step for the frame codec.
package dlc_pkg;

	localparam logic [1:0] KIND_BEGIN = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	localparam logic [2:0] REG_DIRECTION = 3'd0;
	localparam logic [2:0] REG_PROTOCOL  = 3'd1;
	localparam logic [2:0] REG_PRIV_MARK = 3'd2;
	localparam logic [2:0] REG_PUB_MARK  = 3'd3;
	localparam logic [2:0] REG_CRC_INIT  = 3'd4;
	localparam logic [2:0] REG_CRC_POLY  = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_BAD_LEN   = 3'd2;
	localparam logic [2:0] ST_BAD_END   = 3'd3;
	localparam logic [2:0] ST_LRC_ERR   = 3'd4;
	localparam logic [2:0] ST_NO_FRAME  = 3'd5;
	localparam logic [2:0] ST_CRC_ERR   = 3'd6;

	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_PACK  = 4'd1;
	localparam logic [3:0] PH_PCMD  = 4'd2;
	localparam logic [3:0] PH_PID   = 4'd3;
	localparam logic [3:0] PH_PCM   = 4'd4;
	localparam logic [3:0] PH_PLEN  = 4'd5;
	localparam logic [3:0] PH_PPAY  = 4'd6;
	localparam logic [3:0] PH_PLRC  = 4'd7;
	localparam logic [3:0] PH_PEOT  = 4'd8;
	localparam logic [3:0] PH_DONE  = 4'd9;
	localparam logic [3:0] PH_PBODY = 4'd10;

	localparam int JOB_SLOTS = 6;
	localparam logic [15:0] LEN_MAX = 16'hFFFF;
	localparam logic [15:0] HUNT_MIN = 16'd7;

	// Results caused by one input item; the last one may carry the frame status.
	typedef struct packed {
		logic [2:0]                 cnt;
		logic [JOB_SLOTS-1:0][7:0]  bytes;
		logic                       nobyte;
		logic                       done;
		logic [2:0]                 status;
		logic [7:0]                 id;
		logic [7:0]                 cmd;
		logic [15:0]                len;
	} job_t;

	// Reflected CRC-16 over one byte, LSB first.
	function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b,
			logic [15:0] poly);
		logic [15:0] c;
		logic [7:0]  d;
		c = crc;
		d = b;
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ d[0]) begin
				c = (c >> 1) ^ poly;
			end else begin
				c = c >> 1;
			end
			d = d >> 1;
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/dlc_if.sv -----
// Handshake channels of the frame codec: input items, results, register writes.
interface dlc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [7:0] node_id;
	logic [7:0] command_byte;
	logic [7:0] payload_count;
	modport source (output valid, kind, data_byte, node_id, command_byte, payload_count,
		input ready);
	modport sink (input valid, kind, data_byte, node_id, command_byte, payload_count,
		output ready);
endinterface

interface dlc_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        frame_done;
	logic [2:0]  status;
	logic [7:0]  got_id;
	logic [7:0]  got_command;
	logic [15:0] frame_length;
	logic        last;
	modport source (output valid, out_byte, byte_valid, frame_done, status, got_id,
		got_command, frame_length, last, input ready);
	modport sink (input valid, out_byte, byte_valid, frame_done, status, got_id,
		got_command, frame_length, last, output ready);
endinterface

interface dlc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [23:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/dlc_front.sv -----
// Front end: holds configuration and frame state, turns items with results into jobs.
module dlc_front #(
	parameter int MAX_FRAME_BYTES = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	dlc_in_if.sink         in_ch,
	dlc_cfg_if.sink        cfg,
	input  logic           job_ready,
	output logic           job_valid,
	output dlc_pkg::job_t  job
);
	import dlc_pkg::*;

	localparam logic [15:0] MaxBytes = 16'(MAX_FRAME_BYTES);

	logic        dir_q, proto_q;
	logic [23:0] priv_q, pub_q;
	logic [15:0] crc_init_q, crc_poly_q;

	logic [3:0]  phase_q, phase_n;
	logic [15:0] crc_q, crc_n;
	logic [7:0]  lrc_q, lrc_n;
	logic        ep_q, ep_n;
	logic [7:0]  h0_q, h0_n, h1_q, h1_n;
	logic [1:0]  hc_q, hc_n;
	logic [15:0] bc_q, bc_n;
	logic [15:0] ic_q, ic_n;
	logic [7:0]  el_q, el_n;
	logic [7:0]  sid_q, sid_n, scmd_q, scmd_n;
	logic [2:0]  fs_q, fs_n;

	logic [7:0]  esc, sop, eop, sh, sl, eot;
	logic        accept, cfg_wr, clear_end;
	logic [15:0] bc_base, len, bc_inc;
	logic [16:0] sum;
	logic [7:0]  dv, lo, hi;
	job_t        j;

	function automatic job_t push(job_t jb, logic [7:0] v);
		job_t r;
		r = jb;
		r.bytes[r.cnt] = v;
		r.cnt = r.cnt + 3'd1;
		return r;
	endfunction

	assign esc = priv_q[23:16];
	assign sop = priv_q[15:8];
	assign eop = priv_q[7:0];
	assign sh  = pub_q[23:16];
	assign sl  = pub_q[15:8];
	assign eot = pub_q[7:0];

	assign in_ch.ready = job_ready;
	assign cfg.ready   = 1'b1;
	assign accept      = in_ch.valid && in_ch.ready;
	assign cfg_wr      = cfg.valid;

	assign bc_inc = (bc_q == LEN_MAX) ? LEN_MAX : bc_q + 16'd1;
	assign lo = crc_q[7:0];
	assign hi = crc_q[15:8];

	always_comb begin
		phase_n = phase_q; crc_n = crc_q; lrc_n = lrc_q; ep_n = ep_q;
		h0_n = h0_q; h1_n = h1_q; hc_n = hc_q; bc_n = bc_q; ic_n = ic_q;
		el_n = el_q; sid_n = sid_q; scmd_n = scmd_q; fs_n = fs_q;
		j = '0;
		bc_base = bc_q;
		clear_end = 1'b0;
		dv = ep_q ? esc : in_ch.data_byte;
		if (dir_q == 1'b0) begin
			unique case (in_ch.kind)
				KIND_BEGIN: begin
					bc_base = '0;
					ep_n = 1'b0; hc_n = '0; ic_n = '0; fs_n = ST_OK;
					sid_n = in_ch.node_id; scmd_n = in_ch.command_byte;
					el_n = in_ch.payload_count; phase_n = PH_PACK;
					lrc_n = '0; crc_n = crc_init_q;
					if (proto_q == 1'b0) begin
						j = push(j, esc);
						j = push(j, sop);
						j = push(j, in_ch.command_byte);
						if (in_ch.command_byte == esc) j = push(j, esc);
						crc_n = crc_step(crc_init_q, in_ch.command_byte, crc_poly_q);
					end else begin
						j = push(j, sh);
						j = push(j, sl);
						j = push(j, in_ch.node_id);
						j = push(j, in_ch.command_byte);
						j = push(j, in_ch.payload_count);
						lrc_n = sh ^ sl ^ in_ch.node_id ^ in_ch.command_byte
							^ in_ch.payload_count;
					end
				end
				KIND_DATA: begin
					if (phase_q == PH_PACK && ic_q < MaxBytes) begin
						ic_n = ic_q + 16'd1;
						j = push(j, in_ch.data_byte);
						if (proto_q == 1'b0) begin
							crc_n = crc_step(crc_q, in_ch.data_byte, crc_poly_q);
							if (in_ch.data_byte == esc) j = push(j, esc);
						end else begin
							lrc_n = lrc_q ^ in_ch.data_byte;
						end
					end
				end
				KIND_END: begin
					clear_end = 1'b1;
					j.done = 1'b1;
					if (phase_q != PH_PACK) begin
						j.cnt = 3'd1; j.nobyte = 1'b1; j.status = ST_NO_FRAME;
					end else if (proto_q == 1'b0) begin
						j = push(j, lo);
						if (lo == esc) j = push(j, esc);
						j = push(j, hi);
						if (hi == esc) j = push(j, esc);
						j = push(j, esc);
						j = push(j, eop);
						j.status = ST_OK;
					end else begin
						j = push(j, lrc_q);
						j = push(j, eot);
						j.status = ({8'd0, ic_q[15:8]} == 16'd0 && ic_q[7:0] == el_q)
							? ST_OK : ST_BAD_LEN;
					end
				end
				default: ;
			endcase
		end else begin
			unique case (in_ch.kind)
				KIND_BEGIN: begin
					clear_end = 1'b1;
				end
				KIND_DATA: begin
					if (phase_q != PH_DONE && ic_q < MaxBytes) begin
						ic_n = ic_q + 16'd1;
						if (proto_q == 1'b0) begin
							if (phase_q == PH_IDLE) begin
								if (ep_q && in_ch.data_byte == sop) begin
									phase_n = PH_PCMD; crc_n = crc_init_q;
									hc_n = '0; ep_n = 1'b0;
								end else begin
									ep_n = (in_ch.data_byte == esc);
								end
							end else if (phase_q == PH_PCMD || phase_q == PH_PBODY) begin
								if (ep_q && in_ch.data_byte == eop) begin
									ep_n = 1'b0;
									if (phase_q == PH_PCMD || hc_q < 2'd2) begin
										fs_n = ST_SHORT;
									end else if (h0_q == lo && h1_q == hi) begin
										fs_n = ST_OK;
									end else begin
										fs_n = ST_CRC_ERR;
									end
									phase_n = PH_DONE;
								end else if (!ep_q && in_ch.data_byte == esc) begin
									ep_n = 1'b1;
								end else begin
									// deliver the byte, or the escape it stands behind
									ep_n = 1'b0;
									if (phase_q == PH_PCMD) begin
										scmd_n = dv;
										crc_n = crc_step(crc_q, dv, crc_poly_q);
										phase_n = PH_PBODY;
									end else if (hc_q >= 2'd2) begin
										j = push(j, h0_q);
										crc_n = crc_step(crc_q, h0_q, crc_poly_q);
										h0_n = h1_q;
										h1_n = dv;
									end else begin
										if (hc_q[0]) h1_n = dv;
										else h0_n = dv;
										hc_n = hc_q + 2'd1;
									end
								end
							end
						end else begin
							unique case (phase_q)
								PH_IDLE: begin
									if (ep_q && in_ch.data_byte == sl) begin
										phase_n = PH_PID; lrc_n = sh ^ sl; ep_n = 1'b0;
									end else begin
										ep_n = (in_ch.data_byte == sh);
									end
								end
								PH_PID: begin
									sid_n = in_ch.data_byte;
									lrc_n = lrc_q ^ in_ch.data_byte;
									phase_n = PH_PCM;
								end
								PH_PCM: begin
									scmd_n = in_ch.data_byte;
									lrc_n = lrc_q ^ in_ch.data_byte;
									phase_n = PH_PLEN;
								end
								PH_PLEN: begin
									el_n = in_ch.data_byte;
									lrc_n = lrc_q ^ in_ch.data_byte;
									phase_n = (in_ch.data_byte != 8'd0) ? PH_PPAY : PH_PLRC;
								end
								PH_PPAY: begin
									j = push(j, in_ch.data_byte);
									lrc_n = lrc_q ^ in_ch.data_byte;
									if (bc_inc >= {8'd0, el_q}) phase_n = PH_PLRC;
								end
								PH_PLRC: begin
									lrc_n = lrc_q ^ in_ch.data_byte;
									phase_n = PH_PEOT;
								end
								PH_PEOT: begin
									fs_n = (in_ch.data_byte != eot) ? ST_BAD_END :
										((lrc_q != 8'd0) ? ST_LRC_ERR : ST_OK);
									phase_n = PH_DONE;
								end
								default: ;
							endcase
						end
					end
				end
				KIND_END: begin
					clear_end = 1'b1;
					j.done = 1'b1; j.cnt = 3'd1; j.nobyte = 1'b1;
					if (phase_q == PH_IDLE) begin
						j.status = (ic_q < HUNT_MIN) ? ST_SHORT : ST_NO_FRAME;
					end else if (phase_q == PH_DONE) begin
						j.status = fs_q;
					end else if (phase_q == PH_PCMD || phase_q == PH_PBODY) begin
						j.status = ST_BAD_END;
					end else begin
						j.status = ST_BAD_LEN;
					end
				end
				default: ;
			endcase
		end
		sum = {1'b0, bc_base} + {14'd0, j.cnt - {2'd0, j.nobyte}};
		len = sum[16] ? LEN_MAX : sum[15:0];
		bc_n = len;
		j.id  = sid_q;
		j.cmd = scmd_q;
		j.len = len;
		if (clear_end) begin
			phase_n = PH_IDLE; crc_n = crc_init_q; lrc_n = '0; ep_n = 1'b0;
			hc_n = '0; bc_n = '0; ic_n = '0; el_n = '0; sid_n = '0; scmd_n = '0;
			fs_n = ST_OK;
		end
		if (!j.done) begin
			j.id = '0; j.cmd = '0; j.len = '0; j.status = ST_OK;
		end
	end

	assign job       = j;
	assign job_valid = accept && (j.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= 1'b0; proto_q <= 1'b0;
			priv_q <= 24'h100203; pub_q <= '0;
			crc_init_q <= '0; crc_poly_q <= 16'hA001;
			phase_q <= PH_IDLE; crc_q <= '0; lrc_q <= '0; ep_q <= 1'b0;
			hc_q <= '0; bc_q <= '0; ic_q <= '0; el_q <= '0;
			sid_q <= '0; scmd_q <= '0; fs_q <= ST_OK;
		end else if (cfg_wr) begin
			unique case (cfg.index)
				REG_DIRECTION, REG_PROTOCOL: begin
					if (cfg.index == REG_DIRECTION) dir_q <= cfg.data[0];
					else proto_q <= cfg.data[0];
					phase_q <= PH_IDLE; crc_q <= crc_init_q; lrc_q <= '0; ep_q <= 1'b0;
					hc_q <= '0; bc_q <= '0; ic_q <= '0; el_q <= '0;
					sid_q <= '0; scmd_q <= '0; fs_q <= ST_OK;
				end
				REG_PRIV_MARK: priv_q <= cfg.data;
				REG_PUB_MARK:  pub_q <= cfg.data;
				REG_CRC_INIT:  crc_init_q <= cfg.data[15:0];
				REG_CRC_POLY:  crc_poly_q <= cfg.data[15:0];
				default: ;
			endcase
		end else if (accept) begin
			phase_q <= phase_n; crc_q <= crc_n; lrc_q <= lrc_n; ep_q <= ep_n;
			hc_q <= hc_n; bc_q <= bc_n; ic_q <= ic_n; el_q <= el_n;
			sid_q <= sid_n; scmd_q <= scmd_n; fs_q <= fs_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !cfg_wr) begin
			h0_q <= h0_n;
			h1_q <= h1_n;
		end
	end

endmodule

// ----- hw/rtl/dlc_queue.sv -----
// Two-entry job queue between front end and result sender.
module dlc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	input  dlc_pkg::job_t  wr_job,
	output logic           wr_ready,
	output logic           rd_valid,
	output dlc_pkg::job_t  rd_job,
	input  logic           rd_pop
);
	import dlc_pkg::*;

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_wr, do_rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_job   = mem_q[rp_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= ~wp_q;
			if (do_rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_job;
	end

endmodule

// ----- hw/rtl/dlc_back.sv -----
// Result sender: walks the head job and presents one result per cycle while out_ch is ready.
module dlc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  dlc_pkg::job_t  job,
	output logic           job_pop,
	dlc_out_if.source      out_ch
);
	import dlc_pkg::*;

	logic [2:0] idx_q;
	logic       is_last, has_byte, take;

	assign is_last  = (idx_q == job.cnt - 3'd1);
	assign has_byte = !(is_last && job.nobyte);
	assign take     = out_ch.valid && out_ch.ready;
	assign job_pop  = take && is_last;

	assign out_ch.valid        = job_valid;
	assign out_ch.out_byte     = has_byte ? job.bytes[idx_q] : 8'd0;
	assign out_ch.byte_valid   = has_byte;
	assign out_ch.frame_done   = is_last && job.done;
	assign out_ch.status       = (is_last && job.done) ? job.status : 3'd0;
	assign out_ch.got_id       = (is_last && job.done) ? job.id : 8'd0;
	assign out_ch.got_command  = (is_last && job.done) ? job.cmd : 8'd0;
	assign out_ch.frame_length = (is_last && job.done) ? job.len : 16'd0;
	assign out_ch.last         = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
		end
	end

endmodule

// ----- hw/rtl/dle_crc_lrc_frame_codec.sv -----
// Top level of the DLE/CRC-16 and length/LRC frame codec.
// The front end takes one item per cycle while its two-entry job queue has room
// and works out all of that item's results at once; the sender then puts out one
// result per cycle while the output is ready. An item gives at most six results;
// one that gives none puts no job in the queue. Register writes are taken in any
// cycle and belong only in idle periods.
module dle_crc_lrc_frame_codec #(
	parameter int MAX_FRAME_BYTES = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	dlc_in_if.sink    in_ch,
	dlc_out_if.source out_ch,
	dlc_cfg_if.sink   cfg
);
	import dlc_pkg::*;

	job_t f_job, q_job;
	logic f_valid, f_ready, q_valid, q_pop;

	dlc_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .cfg(cfg),
		.job_ready(f_ready), .job_valid(f_valid), .job(f_job)
	);

	dlc_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_job(f_job), .wr_ready(f_ready),
		.rd_valid(q_valid), .rd_job(q_job), .rd_pop(q_pop)
	);

	dlc_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(q_valid), .job(q_job), .job_pop(q_pop), .out_ch(out_ch)
	);

endmodule
